@@ hw/rtl/plai_pkg.sv @@
// ----------------------------------------------------------------------------
// plai_pkg: shared types, format codes and helpers
// Beat types for the line average interpolator and the rounded-mean helpers
// used on each packed component.
// ----------------------------------------------------------------------------
`default_nettype none

package plai_pkg;

    localparam int WORD_BITS  = 32;
    localparam int GROUP_WORDS = 3;
    localparam int FMT_BITS   = 3;

    typedef logic [FMT_BITS-1:0] t_format;

    localparam t_format FMT_8BIT  = 3'd0;
    localparam t_format FMT_16BIT = 3'd1;
    localparam t_format FMT_V210  = 3'd2;
    localparam t_format FMT_R10K  = 3'd3;
    localparam t_format FMT_R12L  = 3'd4;
    localparam t_format FMT_COPY  = 3'd5;

    typedef logic [GROUP_WORDS-1:0][WORD_BITS-1:0] t_group;

    typedef struct packed {
        t_group     upper;
        t_group     lower;
        logic [1:0] valid_words;
    } t_in_beat;

    typedef struct packed {
        t_group mean;
        logic   interpolated;
    } t_out_beat;

    function automatic logic [7:0] mean_8(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b} + 9'd1;
        return s[8:1];
    endfunction

    function automatic logic [9:0] mean_10(input logic [9:0] a, input logic [9:0] b);
        logic [10:0] s;
        s = {1'b0, a} + {1'b0, b} + 11'd1;
        return s[10:1];
    endfunction

    function automatic logic [11:0] mean_12(input logic [11:0] a, input logic [11:0] b);
        logic [12:0] s;
        s = {1'b0, a} + {1'b0, b} + 13'd1;
        return s[12:1];
    endfunction

    function automatic logic [15:0] mean_16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b} + 17'd1;
        return s[16:1];
    endfunction

    function automatic logic [31:0] swap_bytes(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/plai_intf.sv @@
// ----------------------------------------------------------------------------
// plai_intf: valid/ready channels of the line average interpolator
// One interface for the input word groups, one for the result groups.
// ----------------------------------------------------------------------------
`default_nettype none

interface plai_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] upper_word0;
    logic [31:0] upper_word1;
    logic [31:0] upper_word2;
    logic [31:0] lower_word0;
    logic [31:0] lower_word1;
    logic [31:0] lower_word2;
    logic [1:0]  valid_words;

    modport source (
        output valid, upper_word0, upper_word1, upper_word2,
               lower_word0, lower_word1, lower_word2, valid_words,
        input  ready
    );
    modport sink (
        input  valid, upper_word0, upper_word1, upper_word2,
               lower_word0, lower_word1, lower_word2, valid_words,
        output ready
    );
endinterface

interface plai_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] mean_word0;
    logic [31:0] mean_word1;
    logic [31:0] mean_word2;
    logic        interpolated;

    modport source (
        output valid, mean_word0, mean_word1, mean_word2, interpolated,
        input  ready
    );
    modport sink (
        input  valid, mean_word0, mean_word1, mean_word2, interpolated,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/packed_line_average_interpolator_unit.sv @@
// Each accepted input beat is registered in the input register, averaged, and registered again in the result register.
// Throughput: one word group per cycle; input register and result register
// each advance whenever the stage after them is empty or being drained.
// Reset (synchronous, active low) empties both stages and sets the line
// format to 8-bit.
// ----------------------------------------------------------------------------
// packed_line_average_interpolator_unit: deinterlace line interpolator
// Averages packed components of the field lines above and below in a
// two-register pipeline with a format register written over the config port.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_line_average_interpolator_unit
    import plai_pkg::*;
(
    input  var logic    i_clk,
    input  var logic    i_rst_n,
    input  var logic    i_cfg_we,
    input  var t_format i_cfg_data,
    plai_in_if.sink     i_in,
    plai_out_if.source  o_out
);

    t_format   r_line_format;
    logic      r_s1_valid;
    t_in_beat  r_s1_beat;
    logic      r_s2_valid;
    t_out_beat r_s2_beat;
    t_in_beat  in_beat;
    t_out_beat core_beat;
    logic      s1_ready;
    logic      s2_ready;

    assign in_beat.upper       = {i_in.upper_word2, i_in.upper_word1, i_in.upper_word0};
    assign in_beat.lower       = {i_in.lower_word2, i_in.lower_word1, i_in.lower_word0};
    assign in_beat.valid_words = i_in.valid_words;

    assign s2_ready   = !r_s2_valid || o_out.ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign i_in.ready = s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_format <= FMT_8BIT;
        end else if (i_cfg_we) begin
            r_line_format <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    // hold payloads while the downstream stage stalls
    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in.valid) begin
            r_s1_beat <= in_beat;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2_beat <= core_beat;
        end
    end

    plai_mean_core u_core (
        .i_line_format (r_line_format),
        .i_beat        (r_s1_beat),
        .o_beat        (core_beat)
    );

    assign o_out.valid        = r_s2_valid;
    assign o_out.mean_word0   = r_s2_beat.mean[0];
    assign o_out.mean_word1   = r_s2_beat.mean[1];
    assign o_out.mean_word2   = r_s2_beat.mean[2];
    assign o_out.interpolated = r_s2_beat.interpolated;

endmodule

`default_nettype wire

@@ hw/rtl/plai_mean_core.sv @@
// ----------------------------------------------------------------------------
// plai_mean_core: per-format component averaging
// Computes the rounded mean of every packed component for all layouts in
// parallel, picks the configured one and clears unused words.
// ----------------------------------------------------------------------------
`default_nettype none

module plai_mean_core
    import plai_pkg::*;
(
    input  var t_format   i_line_format,
    input  var t_in_beat  i_beat,
    output var t_out_beat o_beat
);

    t_group      w8;
    t_group      w16;
    t_group      wv210;
    t_group      wr10k;
    t_group      sx;
    t_group      sy;
    t_group      res;
    logic [95:0] up96;
    logic [95:0] lo96;
    logic [95:0] w12l;
    logic        flag;

    assign up96 = i_beat.upper;
    assign lo96 = i_beat.lower;

    for (genvar gi = 0; gi < GROUP_WORDS; gi++) begin : g_word
        for (genvar gl = 0; gl < 4; gl++) begin : g_byte
            assign w8[gi][gl*8 +: 8] =
                mean_8(i_beat.upper[gi][gl*8 +: 8], i_beat.lower[gi][gl*8 +: 8]);
        end
        for (genvar gh = 0; gh < 2; gh++) begin : g_half
            assign w16[gi][gh*16 +: 16] =
                mean_16(i_beat.upper[gi][gh*16 +: 16], i_beat.lower[gi][gh*16 +: 16]);
        end

        assign wv210[gi] = {
            mean_12(i_beat.upper[gi][31:20], i_beat.lower[gi][31:20]),
            mean_10(i_beat.upper[gi][19:10], i_beat.lower[gi][19:10]),
            mean_10(i_beat.upper[gi][9:0],   i_beat.lower[gi][9:0])
        };

        // R10k fields live in the byte-swapped word; swap back after averaging
        assign sx[gi] = swap_bytes(i_beat.upper[gi]);
        assign sy[gi] = swap_bytes(i_beat.lower[gi]);
        assign wr10k[gi] = swap_bytes({
            mean_10(sx[gi][31:22], sy[gi][31:22]),
            mean_10(sx[gi][21:12], sy[gi][21:12]),
            mean_10(sx[gi][11:2],  sy[gi][11:2]),
            2'b00
        });

        assign o_beat.mean[gi] = (2'(gi) < i_beat.valid_words) ? res[gi] : '0;
    end

    // R12L: eight 12-bit fields run LSB-first across the whole 96-bit group
    for (genvar gk = 0; gk < 8; gk++) begin : g_r12l
        assign w12l[gk*12 +: 12] = mean_12(up96[gk*12 +: 12], lo96[gk*12 +: 12]);
    end

    always_comb begin
        flag = 1'b1;
        case (i_line_format)
            FMT_8BIT:  res = w8;
            FMT_16BIT: res = w16;
            FMT_V210:  res = wv210;
            FMT_R10K:  res = wr10k;
            FMT_R12L:  res = w12l;
            FMT_COPY: begin
                res  = i_beat.upper;
                flag = 1'b0;
            end
            default: begin
                res  = i_beat.upper;
                flag = 1'b0;
            end
        endcase
    end

    assign o_beat.interpolated = flag;

endmodule

`default_nettype wire

@@ tb/plai_result_checker.sv @@
// ----------------------------------------------------------------------------
// plai_result_checker: result checker for the line average interpolator
// Watches the group and result channels, computes the expected mean words for
// every accepted group under the current line format, and compares each
// result beat field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module plai_result_checker
    import plai_pkg::*;
(
    input  var logic    i_clk,
    input  var logic    i_rst_n,
    input  var logic    i_cfg_we,
    input  var t_format i_cfg_data,
    plai_in_if          i_group_mon,
    plai_out_if         i_result_mon,
    output int          o_fail_count,
    output int          o_pending
);

    t_format   line_format;
    t_out_beat expected_means[$];
    int        fail_count = 0;
    int        pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic logic [31:0] rounded_mean(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b} + 33'd1;
        return sum[32:1];
    endfunction

    function automatic logic [31:0] lane_average(input logic [31:0] a, input logic [31:0] b,
                                                 input int lane_bits);
        logic [31:0] mask;
        logic [31:0] r;
        mask = (32'd1 << lane_bits) - 32'd1;
        r = '0;
        for (int s = 0; s < 32; s += lane_bits)
            r |= rounded_mean((a >> s) & mask, (b >> s) & mask) << s;
        return r;
    endfunction

    function automatic t_out_beat interpolate_group(input t_format fmt, input t_in_beat beat);
        t_out_beat   res;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] m;
        logic [95:0] up96;
        logic [95:0] lo96;
        logic [95:0] mean96;
        res.mean         = '0;
        res.interpolated = 1'b1;
        up96   = beat.upper;
        lo96   = beat.lower;
        mean96 = '0;
        case (fmt)
            FMT_8BIT: begin
                for (int w = 0; w < GROUP_WORDS; w++)
                    res.mean[w] = lane_average(beat.upper[w], beat.lower[w], 8);
            end
            FMT_16BIT: begin
                for (int w = 0; w < GROUP_WORDS; w++)
                    res.mean[w] = lane_average(beat.upper[w], beat.lower[w], 16);
            end
            FMT_V210: begin
                for (int w = 0; w < GROUP_WORDS; w++) begin
                    x = beat.upper[w];
                    y = beat.lower[w];
                    m = rounded_mean(x >> 20, y >> 20) << 20;
                    m |= rounded_mean((x >> 10) & 32'h3ff, (y >> 10) & 32'h3ff) << 10;
                    m |= rounded_mean(x & 32'h3ff, y & 32'h3ff);
                    res.mean[w] = m;
                end
            end
            FMT_R10K: begin
                // fields live in the byte-swapped word; the two low bits stay clear
                for (int w = 0; w < GROUP_WORDS; w++) begin
                    x = {<<8{beat.upper[w]}};
                    y = {<<8{beat.lower[w]}};
                    m = rounded_mean(x >> 22, y >> 22) << 22;
                    m |= rounded_mean((x >> 12) & 32'h3ff, (y >> 12) & 32'h3ff) << 12;
                    m |= rounded_mean((x >> 2) & 32'h3ff, (y >> 2) & 32'h3ff) << 2;
                    res.mean[w] = {<<8{m}};
                end
            end
            FMT_R12L: begin
                // eight 12-bit fields run LSB-first across all 96 bits
                for (int k = 0; k < 8; k++) begin
                    m = rounded_mean(32'(up96[12*k +: 12]), 32'(lo96[12*k +: 12]));
                    mean96[12*k +: 12] = m[11:0];
                end
                res.mean = mean96;
            end
            default: begin
                res.mean         = beat.upper;
                res.interpolated = 1'b0;
            end
        endcase
        for (int w = 0; w < GROUP_WORDS; w++)
            if (w >= beat.valid_words)
                res.mean[w] = '0;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_in_beat  beat;
        t_out_beat got;
        t_out_beat want;
        if (!i_rst_n) begin
            line_format <= FMT_8BIT;
            expected_means.delete();
            pending_count = 0;
        end else begin
            if (i_group_mon.valid && i_group_mon.ready) begin
                beat.upper[0]    = i_group_mon.upper_word0;
                beat.upper[1]    = i_group_mon.upper_word1;
                beat.upper[2]    = i_group_mon.upper_word2;
                beat.lower[0]    = i_group_mon.lower_word0;
                beat.lower[1]    = i_group_mon.lower_word1;
                beat.lower[2]    = i_group_mon.lower_word2;
                beat.valid_words = i_group_mon.valid_words;
                expected_means.push_back(interpolate_group(line_format, beat));
            end
            if (i_result_mon.valid && i_result_mon.ready) begin
                got.mean[0]      = i_result_mon.mean_word0;
                got.mean[1]      = i_result_mon.mean_word1;
                got.mean[2]      = i_result_mon.mean_word2;
                got.interpolated = i_result_mon.interpolated;
                if (expected_means.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding", got.mean[0], '0);
                end else begin
                    want = expected_means.pop_front();
                    for (int w = 0; w < GROUP_WORDS; w++)
                        if (got.mean[w] !== want.mean[w])
                            report_mismatch($sformatf("mean_word%0d", w), got.mean[w],
                                            want.mean[w]);
                    if (got.interpolated !== want.interpolated)
                        report_mismatch("interpolated", 32'(got.interpolated),
                                        32'(want.interpolated));
                end
            end
            if (i_cfg_we)
                line_format <= i_cfg_data;
            pending_count = expected_means.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: regression bench for the line average interpolator
// Drives word groups under every line format code with random gaps on both
// channels, including one long result hold-off, and reports the verdict from
// the result checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module tb_top;
    import plai_pkg::*;

    localparam int      CLK_HALF        = 5;
    localparam int      RESET_CYCLES    = 12;
    localparam int      HOLD_OFF_CYCLES = 80;
    localparam int      DRAIN_CYCLES    = 8;
    localparam int      TIMEOUT_CYCLES  = 600000;
    localparam int      RANDOM_GROUPS   = 1150;
    localparam int      PHASES          = 10;
    localparam t_format FMT_CODE_MAX    = '1;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    cfg_we;
    t_format cfg_data;

    int fail_count;
    int pending;
    int groups_sent   = 0;
    int format_writes = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    bit tx_burst      = 1'b0;
    bit rx_burst      = 1'b0;

    plai_in_if  in_ch();
    plai_out_if out_ch();

    packed_line_average_interpolator_unit uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    plai_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_group_mon  (in_ch),
        .i_result_mon (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // mostly back-to-back, sometimes a short gap, rarely a long pause
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 15);
        return $urandom_range(30, 60);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 11))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    // lower line: equal to the upper one, a low-byte variation of it, its inverse, or random
    function automatic logic [31:0] neighbor_word(input logic [31:0] upper);
        case ($urandom_range(0, 5))
            0: begin
                return upper;
            end
            1: begin
                return upper ^ 32'($urandom_range(0, 255));
            end
            2: begin
                return ~upper;
            end
            default: begin
                return pick_word();
            end
        endcase
    endfunction

    function automatic t_in_beat random_group();
        t_in_beat b;
        for (int w = 0; w < GROUP_WORDS; w++) begin
            b.upper[w] = pick_word();
            b.lower[w] = neighbor_word(b.upper[w]);
        end
        b.valid_words = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 2)) : 2'd3;
        return b;
    endfunction

    task automatic send_group(input t_in_beat beat);
        int n;
        n = tx_burst ? 0 : gap_len();
        repeat (n) begin
            @(negedge clk);
            in_ch.valid = 1'b0;
        end
        @(negedge clk);
        in_ch.valid       = 1'b1;
        in_ch.upper_word0 = beat.upper[0];
        in_ch.upper_word1 = beat.upper[1];
        in_ch.upper_word2 = beat.upper[2];
        in_ch.lower_word0 = beat.lower[0];
        in_ch.lower_word1 = beat.lower[1];
        in_ch.lower_word2 = beat.lower[2];
        in_ch.valid_words = beat.valid_words;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        groups_sent++;
    endtask

    // change format only once the pipeline has drained
    task automatic write_format(input t_format fmt);
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we   = 1'b1;
        cfg_data = fmt;
        @(negedge clk);
        cfg_we = 1'b0;
        format_writes++;
    endtask

    initial begin : result_sink
        int n;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (holds_served != hold_requests) begin
                // hold off while the sender keeps offering, so the input stalls
                holds_served++;
                out_ch.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
            end else if (rx_burst) begin
                out_ch.ready = 1'b1;
            end else begin
                n = gap_len();
                if (n == 0) begin
                    out_ch.ready = 1'b1;
                end else begin
                    out_ch.ready = 1'b0;
                    repeat (n - 1) @(negedge clk);
                end
            end
        end
    end

    initial begin : group_source
        t_in_beat b;
        t_format  fmt;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_data          = FMT_8BIT;
        in_ch.valid       = 1'b0;
        in_ch.upper_word0 = '0;
        in_ch.upper_word1 = '0;
        in_ch.upper_word2 = '0;
        in_ch.lower_word0 = '0;
        in_ch.lower_word1 = '0;
        in_ch.lower_word2 = '0;
        in_ch.valid_words = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // directed: every format code, the first one straight out of reset
        for (int c = 0; c <= FMT_CODE_MAX; c++) begin
            if (c != 0)
                write_format(t_format'(c));
            b.upper       = '1;
            b.lower       = '0;
            b.valid_words = 2'd3;
            send_group(b);
            b.lower       = '1;
            b.valid_words = 2'(c % 4);
            send_group(b);
            b.upper       = {32'h89AB_CDEF, 32'h0123_4567, 32'hFEDC_BA98};
            b.lower       = {32'h7654_3210, 32'hFEDC_BA98, 32'h0000_0001};
            b.valid_words = 2'd3;
            send_group(b);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    fmt = FMT_CODE_MAX;
                end
                1: begin
                    fmt = FMT_8BIT;
                end
                2: begin
                    fmt = FMT_R12L;
                end
                default: begin
                    fmt = t_format'($urandom_range(0, FMT_CODE_MAX));
                end
            endcase
            write_format(fmt);
            tx_burst = (p == 3) || ($urandom_range(0, 3) == 0);
            rx_burst = (p != 3) && ($urandom_range(0, 3) == 0);
            if (p == 3)
                hold_requests++;
            repeat (RANDOM_GROUPS / PHASES) send_group(random_group());
        end

        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d word groups over %0d format settings, codes 0 through %0d",
                 groups_sent, format_writes + 1, FMT_CODE_MAX);
        $display("result side held off %0d time(s) for %0d cycles under a full-rate sender",
                 holds_served, HOLD_OFF_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("packed_line_average_interpolator_unit regression: pass");
        else
            $display("packed_line_average_interpolator_unit regression: fail");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("timeout with %0d result beat(s) outstanding", pending);
        $display("packed_line_average_interpolator_unit regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/plai_pkg.sv
hw/rtl/plai_intf.sv
hw/rtl/plai_mean_core.sv
hw/rtl/packed_line_average_interpolator_unit.sv
tb/plai_result_checker.sv
tb/tb_top.sv
